>>> src/double_ended_queue_macros.svh
// assertion macros shared by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef SYNTH
`define DQE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("double_ended_queue: assertion failed");
`define DQE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("double_ended_queue: assertion failed");
`else
`define DQE_ASSERT(lbl, clk, rst, prop)
`define DQE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/dqe_pkg.sv
// shared types and operation codes of the double-ended queue
package dqe_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int KIND_WIDTH  = 3;
   localparam int COUNT_WIDTH = 5;

   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_READ       = 3'd4;

   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
   } cell_ctrl_type;

endpackage

>>> src/dqe_cell.sv
// one storage cell of the shifting deque chain
module dqe_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dqe_pkg::cell_ctrl_type                  ctrl,
   input  logic signed [dqe_pkg::DATA_WIDTH-1:0]   push_value,
   input  logic signed [dqe_pkg::DATA_WIDTH-1:0]   left_data,
   input  logic                                    left_valid,
   input  logic signed [dqe_pkg::DATA_WIDTH-1:0]   right_data,
   input  logic                                    right_valid,
   output logic signed [dqe_pkg::DATA_WIDTH-1:0]   cell_data,
   output logic                                    cell_valid
);

   logic signed [dqe_pkg::DATA_WIDTH-1:0] data_ff, data_in;
   logic                                  valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_rear) begin
         // first free cell takes the new rear entry
         if (!valid_ff && left_valid) begin
            data_in  = push_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_rear) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign cell_data  = data_ff;
   assign cell_valid = valid_ff;

endmodule

>>> src/double_ended_queue.sv
// top level of the double-ended queue built from a chain of cells
//
// usage:
//   req channel carries one request: req_kind selects push front, push rear,
//   pop front, pop rear or read only (codes above pop rear read only), and
//   req_value is the value pushed. rsp channel returns one response per
//   request with the front and rear values, empty, full, entry count and a
//   rejected flag for a push dropped on a full queue.
//   entries sit in a row of DEPTH cells; the front is always cell 0, and each
//   push front on a non-full queue or pop front on a non-empty queue shifts
//   the whole row by one cell. the cells update at the accepting edge, and the
//   output register loads from them once it is free or being drained.
//   throughput: one request per cycle while rsp_ready stays high.
//   reset clears all cell valid bits, the count and both pipeline flags; the
//   queue is empty and req_ready is high in the first cycle after reset.
//   when the receiver stalls, one response waits in the output register and
//   one more finished request is held; req_ready then drops until the
//   output register drains.
`include "double_ended_queue_macros.svh"
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [dqe_pkg::KIND_WIDTH-1:0]          req_kind,
   input  logic signed [dqe_pkg::DATA_WIDTH-1:0]   req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dqe_pkg::DATA_WIDTH-1:0]   rsp_front_value,
   output logic signed [dqe_pkg::DATA_WIDTH-1:0]   rsp_rear_value,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_is_full,
   output logic [dqe_pkg::COUNT_WIDTH-1:0]         rsp_entry_count,
   output logic                                    rsp_rejected
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [dqe_pkg::DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic signed [dqe_pkg::DATA_WIDTH-1:0] left_data  [DEPTH];
   logic signed [dqe_pkg::DATA_WIDTH-1:0] right_data [DEPTH];
   logic [DEPTH-1:0]                      cell_valid, left_valid, right_valid;
   logic [DEPTH-1:0]                      last_flag;

   dqe_pkg::cell_ctrl_type ctrl;

   logic req_accept, capture, is_full_now, is_empty_now;
   logic is_push, rejected_now;
   logic signed [dqe_pkg::DATA_WIDTH-1:0] rear_sel, front_sel;

   logic [CW-1:0] count_ff, count_in;
   logic [CW+dqe_pkg::COUNT_WIDTH-1:0] count_ext;
   logic done_ff, done_in;
   logic rej_ff, rej_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [dqe_pkg::DATA_WIDTH-1:0] front_ff, rear_ff;
   logic                                  empty_ff, full_ff, rsp_rej_ff;
   logic [dqe_pkg::COUNT_WIDTH-1:0]       count_out_ff;

   assign is_full_now  = cell_valid[DEPTH-1];
   assign is_empty_now = !cell_valid[0];
   assign capture      = done_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !done_ff || capture;
   assign req_accept   = req_valid && req_ready;

   // operation decode
   always_comb begin
      ctrl    = '0;
      is_push = 1'b0;
      unique case (req_kind)
         dqe_pkg::KIND_PUSH_FRONT: begin
            is_push         = 1'b1;
            ctrl.push_front = req_accept && !is_full_now;
         end
         dqe_pkg::KIND_PUSH_REAR: begin
            is_push        = 1'b1;
            ctrl.push_rear = req_accept && !is_full_now;
         end
         dqe_pkg::KIND_POP_FRONT: begin
            ctrl.pop_front = req_accept && !is_empty_now;
         end
         dqe_pkg::KIND_POP_REAR: begin
            ctrl.pop_rear = req_accept && !is_empty_now;
         end
         default: begin
         end
      endcase
   end

   assign rejected_now = req_accept && is_push && is_full_now;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i]  = req_value;
         assign left_valid[i] = 1'b1;
      end else begin : g_mid_left
         assign left_data[i]  = cell_data[i-1];
         assign left_valid[i] = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i]  = '0;
         assign right_valid[i] = 1'b0;
      end else begin : g_mid_right
         assign right_data[i]  = cell_data[i+1];
         assign right_valid[i] = cell_valid[i+1];
      end

      dqe_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_value  (req_value),
         .left_data   (left_data[i]),
         .left_valid  (left_valid[i]),
         .right_data  (right_data[i]),
         .right_valid (right_valid[i]),
         .cell_data   (cell_data[i]),
         .cell_valid  (cell_valid[i])
      );
   end

   // rear is the last valid cell
   assign last_flag = cell_valid & ~right_valid;

   always_comb begin
      rear_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (last_flag[i]) begin
            rear_sel = rear_sel | cell_data[i];
         end
      end
   end

   assign front_sel = cell_valid[0] ? cell_data[0] : '0;

   always_comb begin
      count_in = count_ff;
      if (ctrl.push_front || ctrl.push_rear) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop_front || ctrl.pop_rear) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = {{dqe_pkg::COUNT_WIDTH{1'b0}}, count_ff};

   assign done_in      = req_accept || (done_ff && !capture);
   assign rej_in       = req_accept ? rejected_now : rej_ff;
   assign rsp_valid_in = capture || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rej_ff <= rej_in;
      if (capture) begin
         front_ff     <= front_sel;
         rear_ff      <= rear_sel;
         empty_ff     <= is_empty_now;
         full_ff      <= is_full_now;
         count_out_ff <= count_ext[dqe_pkg::COUNT_WIDTH-1:0];
         rsp_rej_ff   <= rej_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_rear_value  = rear_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_entry_count = count_out_ff;
   assign rsp_rejected    = rsp_rej_ff;

   `DQE_ASSERT(a_count_matches_cells, clock, reset, count_ff == CW'($countones(cell_valid)))
   `DQE_ASSERT(a_cells_contiguous, clock, reset, (cell_valid & (cell_valid + DEPTH'(1))) == '0)
   `DQE_ASSERT_NEXT(a_reject_keeps_count, clock, reset, rejected_now, $stable(count_ff))
   `DQE_ASSERT_NEXT(a_stall_holds_result, clock, reset, done_ff && !capture, done_ff)

endmodule
